// ===== hw/rtl/wgpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgpp_pkg
// Shared types, constants and helpers of the wavefront grid path planner.
// ----------------------------------------------------------------------------
package wgpp_pkg;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int CELLS     = GRID_ROWS * GRID_COLS;
  localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int IDX_W     = $clog2(CELLS);
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int QE_W      = ROW_W + COL_W;
  localparam int LABEL_W   = 13;

  localparam logic [LABEL_W-1:0] LABEL_MAX  = 13'd8191;
  localparam logic [LABEL_W-1:0] GOAL_LABEL = 13'd2;
  localparam logic [LABEL_W-1:0] OBSTACLE   = 13'd1;
  localparam logic [LABEL_W-1:0] FREE_CELL  = 13'd0;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_PLAN  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] MOVE_STAY  = 2'd0;
  localparam logic [1:0] MOVE_MINUS = 2'd1;
  localparam logic [1:0] MOVE_PLUS  = 2'd2;

  localparam logic [3:0] DIR_COUNT = 4'd8;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_CLR, ST_SEED, ST_POP, ST_QRD, ST_LAB, ST_NB,
    ST_WLAB, ST_WNB
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    logic       blocked;
    logic [5:0] goal_row;
    logic [5:0] goal_col;
  } request_t;

  typedef struct packed {
    logic       found;
    logic       point_valid;
    logic [5:0] way_row;
    logic [5:0] way_col;
    logic       last_point;
  } response_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_t;

  typedef struct packed {
    logic  valid;
    cell_t pos;
  } nb_t;

  function automatic logic [IDX_W-1:0] cell_idx(input cell_t p);
    cell_idx = IDX_W'(int'(p.row) * GRID_COLS + int'(p.col));
  endfunction

  // Neighbor order: N, S, W, E, NW, SW, NE, SE.
  function automatic nb_t step_cell(input cell_t p, input logic [2:0] d);
    nb_t        n;
    logic [1:0] rm;
    logic [1:0] cm;
    rm = MOVE_STAY;
    cm = MOVE_STAY;
    case (d)
      3'd0: rm = MOVE_MINUS;
      3'd1: rm = MOVE_PLUS;
      3'd2: cm = MOVE_MINUS;
      3'd3: cm = MOVE_PLUS;
      3'd4: begin rm = MOVE_MINUS; cm = MOVE_MINUS; end
      3'd5: begin rm = MOVE_PLUS;  cm = MOVE_MINUS; end
      3'd6: begin rm = MOVE_MINUS; cm = MOVE_PLUS;  end
      default: begin rm = MOVE_PLUS; cm = MOVE_PLUS; end
    endcase
    n.valid = 1'b1;
    n.pos   = p;
    if (rm == MOVE_MINUS) begin
      n.valid   = n.valid && (p.row != '0);
      n.pos.row = p.row - ROW_W'(1);
    end else if (rm == MOVE_PLUS) begin
      n.valid   = n.valid && (p.row != ROW_W'(GRID_ROWS - 1));
      n.pos.row = p.row + ROW_W'(1);
    end
    if (cm == MOVE_MINUS) begin
      n.valid   = n.valid && (p.col != '0);
      n.pos.col = p.col - COL_W'(1);
    end else if (cm == MOVE_PLUS) begin
      n.valid   = n.valid && (p.col != COL_W'(GRID_COLS - 1));
      n.pos.col = p.col + COL_W'(1);
    end
    step_cell = n;
  endfunction

endpackage

// ===== hw/rtl/wgpp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgpp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wgpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/wavefront_grid_path_planner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wavefront_grid_path_planner_unit
// 8-connected wavefront planner over an occupancy grid held in block RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on request when start is high and busy is low.
//   Every transaction returns exactly one response, shown for one cycle with
//   done high; the receiver cannot stall, so responses are never held.
//   Cell writes, unused kinds and fetches with no pending path respond in
//   the cycle after acceptance. A plan first sweeps the label RAM (one entry
//   per cycle through the single read port), then seeds the goal, or responds
//   not found if start or goal lies off the grid. Each dequeued cell then
//   takes a pop, a queue read, a label read and one neighbor label read per
//   cycle. A waypoint fetch reads the cursor label, then one neighbor per cycle.
//   The label RAM read port paces all of these steps.
//   After rst the block runs a clearing pass over all CELLS label entries
//   (4096 at the default grid) with busy high, then accepts transactions.
// ----------------------------------------------------------------------------
module wavefront_grid_path_planner_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wgpp_pkg::request_t  request,
  output logic                busy,
  output logic                done,
  output wgpp_pkg::response_t response
);

  wgpp_pkg::state_t state, state_next;

  // label memory port
  logic                           l_we;
  logic [wgpp_pkg::IDX_W-1:0]     l_waddr, l_raddr;
  logic [wgpp_pkg::LABEL_W-1:0]   l_wdata, l_rdata;
  // queue memory port
  logic                           q_we;
  logic [wgpp_pkg::IDX_W-1:0]     q_waddr, q_raddr;
  logic [wgpp_pkg::QE_W-1:0]      q_wdata, q_rdata;

  // datapath registers
  logic [wgpp_pkg::CNT_W-1:0]     clr_idx, q_head, q_tail;
  logic                           clr_v;
  logic [wgpp_pkg::IDX_W-1:0]     clr_addr;
  wgpp_pkg::cell_t                start_pos, goal_pos, cur_pos, cursor;
  logic                           plan_ok;
  logic [wgpp_pkg::LABEL_W-1:0]   lab;
  logic [3:0]                     nb_dir;
  logic                           pend;
  wgpp_pkg::cell_t                pend_pos;
  logic                           path_pending;

  wgpp_pkg::cell_t                req_pos, req_goal, q_cell;
  wgpp_pkg::nb_t                  nb;
  logic                           req_in_grid, goal_in_grid;
  logic                           res_fire;
  wgpp_pkg::response_t            res_data;
  logic                           set_pending, clr_pending, set_cursor;
  wgpp_pkg::cell_t                cursor_value;

  assign req_pos.row  = wgpp_pkg::ROW_W'(request.cell_row);
  assign req_pos.col  = wgpp_pkg::COL_W'(request.cell_col);
  assign req_goal.row = wgpp_pkg::ROW_W'(request.goal_row);
  assign req_goal.col = wgpp_pkg::COL_W'(request.goal_col);
  assign req_in_grid  = ({3'b0, request.cell_row} < 9'(wgpp_pkg::GRID_ROWS)) &&
                        ({3'b0, request.cell_col} < 9'(wgpp_pkg::GRID_COLS));
  assign goal_in_grid = ({3'b0, request.goal_row} < 9'(wgpp_pkg::GRID_ROWS)) &&
                        ({3'b0, request.goal_col} < 9'(wgpp_pkg::GRID_COLS));
  assign q_cell       = wgpp_pkg::cell_t'(q_rdata);
  // walk steps around the cursor, wave steps around the dequeued cell
  assign nb           = wgpp_pkg::step_cell((state == wgpp_pkg::ST_WNB) ? cursor : cur_pos,
                                            nb_dir[2:0]);
  assign busy         = (state != wgpp_pkg::ST_IDLE);

  wgpp_ram #(.WIDTH(wgpp_pkg::LABEL_W), .DEPTH(wgpp_pkg::CELLS)) u_label_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  wgpp_ram #(.WIDTH(wgpp_pkg::QE_W), .DEPTH(wgpp_pkg::CELLS)) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wgpp_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory ports and the one-cycle response.
  always_comb begin
    state_next   = state;
    l_we         = 1'b0;
    l_waddr      = clr_idx[wgpp_pkg::IDX_W-1:0];
    l_wdata      = wgpp_pkg::FREE_CELL;
    l_raddr      = wgpp_pkg::cell_idx(cursor);
    q_we         = 1'b0;
    q_waddr      = q_tail[wgpp_pkg::IDX_W-1:0];
    q_wdata      = wgpp_pkg::QE_W'(pend_pos);
    q_raddr      = q_head[wgpp_pkg::IDX_W-1:0];
    res_fire     = 1'b0;
    res_data     = '0;
    set_pending  = 1'b0;
    clr_pending  = 1'b0;
    set_cursor   = 1'b0;
    cursor_value = '0;
    case (state)
      wgpp_pkg::ST_INIT: begin
        l_we = 1'b1;
        if (clr_idx == wgpp_pkg::CNT_W'(wgpp_pkg::CELLS - 1)) begin
          state_next = wgpp_pkg::ST_IDLE;
        end
      end
      wgpp_pkg::ST_IDLE: begin
        if (start) begin
          case (request.kind)
            wgpp_pkg::KIND_WRITE: begin
              l_we     = req_in_grid;
              l_waddr  = wgpp_pkg::cell_idx(req_pos);
              l_wdata  = request.blocked ? wgpp_pkg::OBSTACLE : wgpp_pkg::FREE_CELL;
              res_fire = 1'b1;
            end
            wgpp_pkg::KIND_PLAN: begin
              state_next = wgpp_pkg::ST_CLR;
            end
            wgpp_pkg::KIND_FETCH: begin
              if (path_pending) begin
                state_next = wgpp_pkg::ST_WLAB;
              end else begin
                res_fire = 1'b1;
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      wgpp_pkg::ST_CLR: begin
        // read one entry per cycle, drop wave labels of the previous entry
        l_raddr = clr_idx[wgpp_pkg::IDX_W-1:0];
        l_waddr = clr_addr;
        l_we    = clr_v && (l_rdata >= wgpp_pkg::GOAL_LABEL);
        if (clr_idx == wgpp_pkg::CNT_W'(wgpp_pkg::CELLS) && !clr_v) begin
          state_next = wgpp_pkg::ST_SEED;
        end
      end
      wgpp_pkg::ST_SEED: begin
        if (!plan_ok) begin
          res_fire    = 1'b1;
          clr_pending = 1'b1;
          set_cursor  = 1'b1;
          state_next  = wgpp_pkg::ST_IDLE;
        end else begin
          l_we       = 1'b1;
          l_waddr    = wgpp_pkg::cell_idx(goal_pos);
          l_wdata    = wgpp_pkg::GOAL_LABEL;
          q_we       = 1'b1;
          q_waddr    = '0;
          q_wdata    = wgpp_pkg::QE_W'(goal_pos);
          state_next = wgpp_pkg::ST_POP;
        end
      end
      wgpp_pkg::ST_POP: begin
        if (q_head == q_tail) begin
          res_fire    = 1'b1;
          clr_pending = 1'b1;
          set_cursor  = 1'b1;
          state_next  = wgpp_pkg::ST_IDLE;
        end else begin
          state_next = wgpp_pkg::ST_QRD;
        end
      end
      wgpp_pkg::ST_QRD: begin
        l_raddr    = wgpp_pkg::cell_idx(q_cell);
        state_next = wgpp_pkg::ST_LAB;
      end
      wgpp_pkg::ST_LAB: begin
        if (cur_pos == start_pos) begin
          res_fire       = 1'b1;
          res_data.found = 1'b1;
          set_pending    = 1'b1;
          set_cursor     = 1'b1;
          cursor_value   = start_pos;
          state_next     = wgpp_pkg::ST_IDLE;
        end else if (l_rdata >= wgpp_pkg::LABEL_MAX) begin
          state_next = wgpp_pkg::ST_POP;
        end else begin
          state_next = wgpp_pkg::ST_NB;
        end
      end
      wgpp_pkg::ST_NB: begin
        // label the neighbor read last cycle, issue the next read
        l_raddr = wgpp_pkg::cell_idx(nb.pos);
        l_waddr = wgpp_pkg::cell_idx(pend_pos);
        l_wdata = lab + wgpp_pkg::LABEL_W'(1);
        if (pend && (l_rdata == wgpp_pkg::FREE_CELL) &&
            (q_tail < wgpp_pkg::CNT_W'(wgpp_pkg::CELLS))) begin
          l_we = 1'b1;
          q_we = 1'b1;
        end
        if (nb_dir == wgpp_pkg::DIR_COUNT) begin
          state_next = wgpp_pkg::ST_POP;
        end
      end
      wgpp_pkg::ST_WLAB: begin
        if (l_rdata > wgpp_pkg::GOAL_LABEL) begin
          state_next = wgpp_pkg::ST_WNB;
        end else begin
          res_fire             = 1'b1;
          res_data.point_valid = 1'b1;
          res_data.way_row     = 6'(cursor.row);
          res_data.way_col     = 6'(cursor.col);
          res_data.last_point  = 1'b1;
          clr_pending          = 1'b1;
          set_cursor           = 1'b1;
          state_next           = wgpp_pkg::ST_IDLE;
        end
      end
      wgpp_pkg::ST_WNB: begin
        l_raddr              = wgpp_pkg::cell_idx(nb.pos);
        res_data.point_valid = 1'b1;
        res_data.way_row     = 6'(cursor.row);
        res_data.way_col     = 6'(cursor.col);
        if (pend && (l_rdata == lab - wgpp_pkg::LABEL_W'(1))) begin
          res_fire     = 1'b1;
          set_cursor   = 1'b1;
          cursor_value = pend_pos;
          state_next   = wgpp_pkg::ST_IDLE;
        end else if (nb_dir == wgpp_pkg::DIR_COUNT) begin
          res_fire            = 1'b1;
          res_data.last_point = 1'b1;
          clr_pending         = 1'b1;
          set_cursor          = 1'b1;
          state_next          = wgpp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wgpp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx      <= '0;
      clr_v        <= 1'b0;
      q_head       <= '0;
      q_tail       <= '0;
      nb_dir       <= '0;
      pend         <= 1'b0;
      path_pending <= 1'b0;
      cursor       <= '0;
      done         <= 1'b0;
    end else begin
      done <= res_fire;
      if (set_pending) begin
        path_pending <= 1'b1;
      end else if (clr_pending) begin
        path_pending <= 1'b0;
      end
      if (set_cursor) begin
        cursor <= cursor_value;
      end
      case (state)
        wgpp_pkg::ST_INIT: begin
          clr_idx <= (clr_idx == wgpp_pkg::CNT_W'(wgpp_pkg::CELLS - 1)) ? '0
                     : clr_idx + wgpp_pkg::CNT_W'(1);
        end
        wgpp_pkg::ST_IDLE: begin
          clr_idx <= '0;
          clr_v   <= 1'b0;
          nb_dir  <= '0;
          pend    <= 1'b0;
        end
        wgpp_pkg::ST_CLR: begin
          clr_v <= (clr_idx != wgpp_pkg::CNT_W'(wgpp_pkg::CELLS));
          if (clr_idx != wgpp_pkg::CNT_W'(wgpp_pkg::CELLS)) begin
            clr_idx <= clr_idx + wgpp_pkg::CNT_W'(1);
          end
          q_head <= '0;
          q_tail <= '0;
        end
        wgpp_pkg::ST_SEED: begin
          if (plan_ok) begin
            q_tail <= wgpp_pkg::CNT_W'(1);
          end
        end
        wgpp_pkg::ST_POP: begin
          if (q_head != q_tail) begin
            q_head <= q_head + wgpp_pkg::CNT_W'(1);
          end
          nb_dir <= '0;
          pend   <= 1'b0;
        end
        wgpp_pkg::ST_NB, wgpp_pkg::ST_WNB: begin
          if (state == wgpp_pkg::ST_NB && q_we) begin
            q_tail <= q_tail + wgpp_pkg::CNT_W'(1);
          end
          if (nb_dir != wgpp_pkg::DIR_COUNT) begin
            pend   <= nb.valid;
            nb_dir <= nb_dir + 4'd1;
          end else begin
            pend <= 1'b0;
          end
        end
        default: begin
          nb_dir <= '0;
          pend   <= 1'b0;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    response <= res_data;
    clr_addr <= clr_idx[wgpp_pkg::IDX_W-1:0];
    pend_pos <= nb.pos;
    if (state == wgpp_pkg::ST_IDLE && start) begin
      start_pos <= req_pos;
      goal_pos  <= req_goal;
      plan_ok   <= req_in_grid && goal_in_grid;
    end
    if (state == wgpp_pkg::ST_QRD) begin
      cur_pos <= q_cell;
    end
    if (state == wgpp_pkg::ST_LAB || state == wgpp_pkg::ST_WLAB) begin
      lab <= l_rdata;
    end
  end

  // Queue indices stay ordered and bounded by the grid size.
  assert property (@(posedge clk) disable iff (rst) q_head <= q_tail)
    else $error("queue head passed tail");
  assert property (@(posedge clk) disable iff (rst)
                   q_tail <= wgpp_pkg::CNT_W'(wgpp_pkg::CELLS))
    else $error("queue tail overflow");
  // A plan result never carries a waypoint.
  assert property (@(posedge clk) disable iff (rst)
                   done && response.found |-> !response.point_valid)
    else $error("found and point_valid together");
  // A successful plan leaves a pending walk.
  assert property (@(posedge clk) disable iff (rst)
                   done && response.found |-> path_pending)
    else $error("found plan without pending walk");
  // No response while idle without an accepted transaction the cycle before.
  assert property (@(posedge clk) disable iff (rst)
                   done |-> $past(busy) || $past(start))
    else $error("response without transaction");

endmodule

// ===== test/wgpp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgpp_checker
// Watches the request and response channels of the planner, keeps its own
// grid and wave model, and compares every response with the expected one.
// ----------------------------------------------------------------------------
module wgpp_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  wgpp_pkg::request_t  request,
  input  logic                done,
  input  wgpp_pkg::response_t response,
  output int                  fail_count,
  output int                  pending_count,
  output int                  plans_found,
  output int                  points_seen
);

  logic [wgpp_pkg::LABEL_W-1:0] grid_label [wgpp_pkg::CELLS];
  int                           bfs_queue  [wgpp_pkg::CELLS];
  int                           walk_at;
  logic                         walk_live;
  wgpp_pkg::response_t          expected_q [$];

  function automatic int nb_index(int r, int c, int d);
    int dr [8];
    int dc [8];
    int nr;
    int nc;
    dr = '{-1, 1, 0, 0, -1, 1, -1, 1};
    dc = '{0, 0, -1, 1, -1, -1, 1, 1};
    nr = r + dr[d];
    nc = c + dc[d];
    if (nr < 0 || nr >= wgpp_pkg::GRID_ROWS || nc < 0 || nc >= wgpp_pkg::GRID_COLS)
      return -1;
    return nr * wgpp_pkg::GRID_COLS + nc;
  endfunction

  function automatic logic spread_wave(int sr, int sc, int gr, int gc);
    int head;
    int tail;
    int cur;
    int n;
    logic [wgpp_pkg::LABEL_W-1:0] lab;
    for (int i = 0; i < wgpp_pkg::CELLS; i++)
      if (grid_label[i] >= wgpp_pkg::GOAL_LABEL) grid_label[i] = wgpp_pkg::FREE_CELL;
    if (sr >= wgpp_pkg::GRID_ROWS || sc >= wgpp_pkg::GRID_COLS ||
        gr >= wgpp_pkg::GRID_ROWS || gc >= wgpp_pkg::GRID_COLS)
      return 1'b0;
    head = 0;
    tail = 0;
    grid_label[gr * wgpp_pkg::GRID_COLS + gc] = wgpp_pkg::GOAL_LABEL;
    bfs_queue[tail++] = gr * wgpp_pkg::GRID_COLS + gc;
    while (head < tail) begin
      cur = bfs_queue[head++];
      lab = grid_label[cur];
      if (cur / wgpp_pkg::GRID_COLS == sr && cur % wgpp_pkg::GRID_COLS == sc) return 1'b1;
      if (lab >= wgpp_pkg::LABEL_MAX) continue;
      for (int d = 0; d < 8; d++) begin
        n = nb_index(cur / wgpp_pkg::GRID_COLS, cur % wgpp_pkg::GRID_COLS, d);
        if (n >= 0 && grid_label[n] == wgpp_pkg::FREE_CELL && tail < wgpp_pkg::CELLS) begin
          grid_label[n] = lab + 1'b1;
          bfs_queue[tail++] = n;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic wgpp_pkg::response_t predict_response(wgpp_pkg::request_t rq);
    wgpp_pkg::response_t rs;
    logic      ok;
    int        r;
    int        c;
    int        n;
    logic [wgpp_pkg::LABEL_W-1:0] lab;
    rs = '0;
    if (rq.kind == wgpp_pkg::KIND_WRITE) begin
      if (rq.cell_row < wgpp_pkg::GRID_ROWS && rq.cell_col < wgpp_pkg::GRID_COLS)
        grid_label[rq.cell_row * wgpp_pkg::GRID_COLS + rq.cell_col] =
          rq.blocked ? wgpp_pkg::OBSTACLE : wgpp_pkg::FREE_CELL;
    end else if (rq.kind == wgpp_pkg::KIND_PLAN) begin
      ok = spread_wave(rq.cell_row, rq.cell_col, rq.goal_row, rq.goal_col);
      rs.found  = ok;
      walk_live = ok;
      walk_at   = ok ? rq.cell_row * wgpp_pkg::GRID_COLS + rq.cell_col : 0;
    end else if (rq.kind == wgpp_pkg::KIND_FETCH && walk_live) begin
      r   = walk_at / wgpp_pkg::GRID_COLS;
      c   = walk_at % wgpp_pkg::GRID_COLS;
      lab = grid_label[walk_at];
      rs.point_valid = 1'b1;
      rs.way_row     = 6'(r);
      rs.way_col     = 6'(c);
      rs.last_point  = 1'b1;
      if (lab > wgpp_pkg::GOAL_LABEL) begin
        for (int d = 0; d < 8; d++) begin
          n = nb_index(r, c, d);
          if (n >= 0 && grid_label[n] == lab - 1'b1) begin
            walk_at = n;
            rs.last_point = 1'b0;
            break;
          end
        end
      end
      if (rs.last_point) begin
        walk_live = 1'b0;
        walk_at   = 0;
      end
    end
    return rs;
  endfunction

  always @(posedge clk) begin
    wgpp_pkg::response_t want;
    if (rst) begin
      for (int i = 0; i < wgpp_pkg::CELLS; i++) grid_label[i] = wgpp_pkg::FREE_CELL;
      walk_at    = 0;
      walk_live  = 1'b0;
      expected_q.delete();
      fail_count    <= 0;
      pending_count <= 0;
      plans_found   <= 0;
      points_seen   <= 0;
    end else begin
      // check the response before queueing this edge's request
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("response with no request outstanding: %p", response);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.found !== response.found)
            $error("found: expected %0d actual %0d", want.found, response.found);
          if (want.point_valid !== response.point_valid)
            $error("point_valid: expected %0d actual %0d", want.point_valid,
                   response.point_valid);
          if (want.way_row !== response.way_row)
            $error("way_row: expected %0d actual %0d", want.way_row, response.way_row);
          if (want.way_col !== response.way_col)
            $error("way_col: expected %0d actual %0d", want.way_col, response.way_col);
          if (want.last_point !== response.last_point)
            $error("last_point: expected %0d actual %0d", want.last_point,
                   response.last_point);
          if (want !== response) fail_count <= fail_count + 1;
          if (response.found) plans_found <= plans_found + 1;
          if (response.point_valid) points_seen <= points_seen + 1;
        end
      end
      if (start && !busy) expected_q.push_back(predict_response(request));
      pending_count <= expected_q.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives writes, plans and waypoint walks into the wavefront planner on small
// obstacle maps; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

  // Watchdog limit, set well above the length of a full-grid plan.
  localparam int STALL_LIMIT = 300000;
  localparam int REQ_W       = $bits(wgpp_pkg::request_t);

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  wgpp_pkg::request_t  request = '0;
  logic                busy;
  logic                done;
  wgpp_pkg::response_t response;
  int                  fail_count;
  int                  pending_count;
  int                  plans_found;
  int                  points_seen;
  int                  idle_pct = 0;
  int                  quiet_cycles = 0;
  int                  sent = 0;

  always #1 clk = ~clk;

  wavefront_grid_path_planner_unit u_top (
    .clk(clk), .rst(rst), .start(start), .request(request),
    .busy(busy), .done(done), .response(response)
  );

  wgpp_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .done(done), .response(response), .fail_count(fail_count),
    .pending_count(pending_count), .plans_found(plans_found),
    .points_seen(points_seen)
  );

  // Watchdog: end the run after too long with no transaction accepted and no response.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAIL wavefront_grid_path_planner_unit");
      $finish;
    end
  end

  // Idle for a while, then present one transaction and hold it until accepted.
  // Start stays high afterwards; the next call drops it or replaces the request.
  task automatic issue(wgpp_pkg::request_t rq);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic put_cell(int r, int c, logic blk);
    wgpp_pkg::request_t rq;
    rq = '0;
    rq.kind = wgpp_pkg::KIND_WRITE;
    rq.cell_row = 6'(r);
    rq.cell_col = 6'(c);
    rq.blocked = blk;
    issue(rq);
  endtask

  task automatic plan_path(int sr, int sc, int gr, int gc);
    wgpp_pkg::request_t rq;
    rq = '0;
    rq.kind = wgpp_pkg::KIND_PLAN;
    rq.cell_row = 6'(sr);
    rq.cell_col = 6'(sc);
    rq.goal_row = 6'(gr);
    rq.goal_col = 6'(gc);
    rq.blocked = 1'($urandom);
    issue(rq);
  endtask

  task automatic fetch_point();
    wgpp_pkg::request_t rq;
    rq = REQ_W'($urandom);
    rq.kind = wgpp_pkg::KIND_FETCH;
    issue(rq);
  endtask

  initial begin
    wgpp_pkg::request_t rq;
    int       sr;
    int       sc;
    int       walk_len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: fetch with no path, unused kind, start equals goal.
    idle_pct = 0;
    fetch_point();
    rq = REQ_W'($urandom);
    rq.kind = wgpp_pkg::KIND_SPARE;
    issue(rq);
    plan_path(5, 5, 5, 5);
    fetch_point();
    fetch_point();
    // A short wall between (0,0) and (3,0), a plan around it, then walk it.
    put_cell(1, 0, 1'b1);
    put_cell(1, 1, 1'b1);
    put_cell(63, 63, 1'b1);
    put_cell(0, 63, 1'b0);
    plan_path(0, 0, 3, 0);
    repeat (5) fetch_point();
    // Goal on obstacle, start on obstacle.
    plan_path(2, 2, 1, 1);
    fetch_point();
    plan_path(1, 0, 2, 0);
    fetch_point();
    // Break a walk by rewriting cells mid-path.
    plan_path(0, 0, 4, 4);
    fetch_point();
    put_cell(1, 1, 1'b1);
    put_cell(0, 1, 1'b1);
    put_cell(1, 0, 1'b1);
    fetch_point();
    fetch_point();
    put_cell(0, 1, 1'b0);

    // Random: plans are mostly short walks on obstacle-sprinkled maps.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 19 : (ph == 1) ? 73 : 0;
      while (sent < 300 * (ph + 1) - 30) begin
        case ($urandom_range(9))
          0, 1, 2, 3: put_cell($urandom_range(7), $urandom_range(7),
                               $urandom_range(99) < 30);
          4: begin
            rq = REQ_W'($urandom);
            rq.kind = wgpp_pkg::KIND_WRITE;
            issue(rq);
          end
          5, 6, 7: begin
            sr = $urandom_range(7);
            sc = $urandom_range(7);
            plan_path(sr, sc, $urandom_range(7), $urandom_range(7));
            walk_len = $urandom_range(10);
            repeat (walk_len) fetch_point();
          end
          8: begin
            if ($urandom_range(19) == 0)
              plan_path($urandom_range(63), $urandom_range(63),
                        $urandom_range(63), $urandom_range(63));
            else fetch_point();
          end
          default: begin
            rq = REQ_W'($urandom);
            if (rq.kind == wgpp_pkg::KIND_PLAN) rq.kind = wgpp_pkg::KIND_FETCH;
            issue(rq);
          end
        endcase
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d transactions: %0d plans found, %0d waypoints walked.",
             sent, plans_found, points_seen);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS wavefront_grid_path_planner_unit");
    end else begin
      $display("FAIL wavefront_grid_path_planner_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wgpp_pkg.sv
hw/rtl/wgpp_ram.sv
hw/rtl/wavefront_grid_path_planner_unit.sv
test/wgpp_checker.sv
test/tb_top.sv
